// ----- src/tccjl_pkg.sv -----
// Shared types, codes and the type K voltage table for the thermocouple linearizer.
package tccjl_pkg;

    // Type K table, one entry per degree from -40 to 150 degC.
    localparam int TAB_N    = 191;
    localparam int TAB_AW   = $clog2(TAB_N);
    localparam int MIN_DEG  = 40;
    localparam int CJ_OFS   = MIN_DEG * 32;
    localparam int TOP_TEMP = (TAB_N - 1 - MIN_DEG) * 32;
    localparam int FRAC_W   = 5;
    localparam int REM_W    = 15;
    localparam int UV_NUM   = 128;
    localparam int UV_DEN   = 125;
    localparam int UV_RND   = 62;

    typedef logic signed [13:0] t_temp;
    typedef logic signed [13:0] t_tval;
    typedef logic signed [19:0] t_volt;
    typedef logic [TAB_AW-1:0]  t_tidx;
    typedef t_tval              t_ktab [TAB_N];

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CJ,
        ST_RANGE,
        ST_SEARCH,
        ST_SEGW,
        ST_WID,
        ST_DIV,
        ST_HYST
    } t_state;

    localparam logic [1:0] CH_CJ   = 2'd0;
    localparam logic [1:0] CH_TC1  = 2'd1;
    localparam logic [1:0] CH_TC2  = 2'd2;
    localparam logic [1:0] CH_NONE = 2'd3;

    localparam logic [1:0] RS_IN   = 2'd0;
    localparam logic [1:0] RS_LOW  = 2'd1;
    localparam logic [1:0] RS_HIGH = 2'd2;

    localparam logic [7:0] THR_RESET = 8'd6;
    localparam t_temp      CJ_RESET  = 14'sd800;

    // Table voltages in microvolts.
    localparam int K_UV [TAB_N] = '{
        -1527,
        -1490, -1453, -1416, -1379, -1342, -1305, -1268, -1231, -1193, -1156,
        -1118, -1081, -1043, -1005, -968, -930, -892, -854, -816, -777,
        -739, -701, -662, -624, -585, -547, -508, -469, -431, -392,
        -353, -314, -275, -236, -197, -157, -118, -79, -39, 0,
        39, 79, 119, 158, 198, 238, 277, 317, 357, 397,
        437, 477, 517, 557, 597, 637, 677, 718, 758, 798,
        838, 879, 919, 960, 1000, 1041, 1081, 1122, 1162, 1203,
        1244, 1285, 1325, 1366, 1407, 1448, 1489, 1529, 1570, 1611,
        1652, 1693, 1734, 1776, 1817, 1858, 1899, 1940, 1981, 2022,
        2064, 2105, 2146, 2188, 2229, 2270, 2312, 2353, 2394, 2436,
        2477, 2519, 2560, 2601, 2643, 2684, 2726, 2767, 2809, 2850,
        2892, 2933, 2975, 3016, 3058, 3100, 3141, 3183, 3224, 3266,
        3307, 3349, 3390, 3432, 3473, 3515, 3556, 3598, 3639, 3681,
        3722, 3764, 3805, 3847, 3888, 3930, 3971, 4012, 4054, 4095,
        4137, 4178, 4219, 4261, 4302, 4343, 4384, 4426, 4467, 4508,
        4549, 4590, 4632, 4673, 4714, 4755, 4796, 4837, 4878, 4919,
        4960, 5001, 5042, 5083, 5124, 5164, 5205, 5246, 5287, 5327,
        5368, 5409, 5450, 5490, 5531, 5571, 5612, 5652, 5693, 5733,
        5774, 5814, 5855, 5895, 5936, 5976, 6016, 6057, 6097, 6137
    };

    // Microvolts to 1/1024 mV, rounded to nearest, away from zero on ties.
    function automatic int uv_scale(input int u);
        int r;
        r = (u * UV_NUM + ((u < 0) ? -UV_RND : UV_RND)) / UV_DEN;
        return r;
    endfunction

    function automatic t_ktab build_ktab();
        t_ktab t;
        for (int i = 0; i < TAB_N; i++) begin
            t[i] = t_tval'(uv_scale(K_UV[i]));
        end
        return t;
    endfunction

    localparam t_ktab KTAB = build_ktab();

endpackage

// ----- src/thermocouple_cold_junction_linearizer.sv -----
// Type K thermocouple linearizer with cold-junction compensation and per-channel hysteresis.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_in_valid, o_in_ready, i_channel,        | in
//          | i_raw_code                                |
//  output  | o_out_valid, i_out_ready, o_temperature,  | out
//          | o_range_status, o_updated                 |
//  config  | i_cfg_we, i_cfg_wdata                     | in
//
// A cold-junction beat goes from acceptance straight to the hysteresis step; a thermocouple
// beat inside the table runs the cold-junction add, range check, binary search (up to 8 steps
// on the one table read port) and the 5-step restoring divider; a clamped one skips both.
// Channel three beats are accepted and dropped. One beat is in work at a time.
// Reset is synchronous; the threshold, cold junction and held values return to reset values.
// A result waiting in the output register stalls the block only when the next one is done.
module thermocouple_cold_junction_linearizer
    import tccjl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_channel,
    input  logic signed [15:0] i_raw_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [13:0] o_temperature,
    output logic [1:0]  o_range_status,
    output logic        o_updated,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata
);

    t_state              r_state, n_state;
    logic [1:0]          r_ch, n_ch;
    logic signed [15:0]  r_code, n_code;
    t_volt               r_v, n_v;
    t_tidx               r_lo, n_lo;
    t_tidx               r_hi, n_hi;
    t_tval               r_tlo, n_tlo;
    logic [REM_W-1:0]    r_rem, n_rem;
    logic [REM_W-1:0]    r_den, n_den;
    logic [FRAC_W-1:0]   r_quo, n_quo;
    logic [2:0]          r_cnt, n_cnt;
    t_temp               r_fresh, n_fresh;
    logic [1:0]          r_status, n_status;
    t_temp               r_cj, n_cj;
    t_temp               r_held [3];
    t_temp               n_held [3];
    logic [7:0]          r_thr, n_thr;
    logic                r_out_valid, n_out_valid;
    t_temp               r_out_temp, n_out_temp;
    logic [1:0]          r_out_status, n_out_status;
    logic                r_out_upd, n_out_upd;

    t_tidx               tab_addr;
    t_tval               tab_rd;
    logic signed [14:0]  cj_sum;
    logic [8:0]          cj_deg;
    t_tidx               cj_idx;
    logic [8:0]          mid_sum;
    t_tidx               mid;
    logic [REM_W:0]      rem_sh;
    logic signed [14:0]  diff;
    logic [14:0]         diff_abs;

    // Cold-junction degree index, clamped to the table.
    always_comb begin
        cj_sum = 15'(r_cj) + 15'(CJ_OFS);
        cj_deg = cj_sum[13:5];
        if (cj_sum < 0) begin
            cj_idx = '0;
        end else if (cj_deg > 9'(TAB_N - 1)) begin
            cj_idx = t_tidx'(TAB_N - 1);
        end else begin
            cj_idx = cj_deg[TAB_AW-1:0];
        end
    end

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[TAB_AW:1];

    // The single table read port, steered by the sequencer.
    always_comb begin
        case (r_state)
            ST_CJ:     tab_addr = cj_idx;
            ST_SEARCH: tab_addr = mid;
            ST_WID:    tab_addr = r_lo + t_tidx'(1);
            default:   tab_addr = r_lo;
        endcase
    end

    assign tab_rd   = KTAB[tab_addr];
    assign rem_sh   = {r_rem, 1'b0};
    assign diff     = 15'(r_fresh) - 15'(r_held[r_ch]);
    assign diff_abs = (diff < 0) ? 15'(-diff) : 15'(diff);

    always_comb begin
        n_state      = r_state;
        n_ch         = r_ch;
        n_code       = r_code;
        n_v          = r_v;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_tlo        = r_tlo;
        n_rem        = r_rem;
        n_den        = r_den;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_fresh      = r_fresh;
        n_status     = r_status;
        n_cj         = r_cj;
        n_held       = r_held;
        n_thr        = i_cfg_we ? i_cfg_wdata : r_thr;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_temp   = r_out_temp;
        n_out_status = r_out_status;
        n_out_upd    = r_out_upd;
        o_in_ready   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                // No beat is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_ch   = i_channel;
                    n_code = i_raw_code;
                    if (i_channel inside {CH_TC1, CH_TC2}) begin
                        n_state = ST_CJ;
                    end else if (i_channel == CH_CJ) begin
                        n_fresh  = t_temp'(i_raw_code >>> 2);
                        n_status = RS_IN;
                        n_state  = ST_HYST;
                    end
                end
            end
            ST_CJ: begin
                n_v     = t_volt'($signed({r_code[15], r_code, 3'b000})) + t_volt'(tab_rd);
                n_state = ST_RANGE;
            end
            ST_RANGE: begin
                if (r_v < t_volt'(KTAB[0])) begin
                    n_fresh  = t_temp'(-CJ_OFS);
                    n_status = RS_LOW;
                    n_state  = ST_HYST;
                end else if (r_v >= t_volt'(KTAB[TAB_N-1])) begin
                    n_fresh  = t_temp'(TOP_TEMP);
                    n_status = RS_HIGH;
                    n_state  = ST_HYST;
                end else begin
                    n_lo     = '0;
                    n_hi     = t_tidx'(TAB_N - 1);
                    n_status = RS_IN;
                    n_state  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // Table entry at lo is at or below the voltage, entry at hi above it.
                if (r_hi - r_lo == t_tidx'(1)) begin
                    n_state = ST_SEGW;
                end else if (r_v >= t_volt'(tab_rd)) begin
                    n_lo = mid;
                end else begin
                    n_hi = mid;
                end
            end
            ST_SEGW: begin
                n_tlo   = tab_rd;
                n_rem   = REM_W'(r_v - t_volt'(tab_rd));
                n_state = ST_WID;
            end
            ST_WID: begin
                n_den   = REM_W'(15'(tab_rd) - 15'(r_tlo));
                n_quo   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_den == '0) begin
                    n_fresh = t_temp'({1'b0, r_lo, {FRAC_W{1'b0}}}) - t_temp'(CJ_OFS);
                    n_state = ST_HYST;
                end else begin
                    // Remainder stays below the segment width, so one subtract per bit.
                    if (rem_sh >= {1'b0, r_den}) begin
                        n_rem = REM_W'(rem_sh - {1'b0, r_den});
                        n_quo = {r_quo[FRAC_W-2:0], 1'b1};
                    end else begin
                        n_rem = rem_sh[REM_W-1:0];
                        n_quo = {r_quo[FRAC_W-2:0], 1'b0};
                    end
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'(FRAC_W - 1)) begin
                        n_fresh = t_temp'({1'b0, r_lo, n_quo}) - t_temp'(CJ_OFS);
                        n_state = ST_HYST;
                    end
                end
            end
            ST_HYST: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_ch == CH_CJ) begin
                        n_cj = r_fresh;
                    end
                    if (diff_abs > {7'b0, r_thr}) begin
                        n_held[r_ch] = r_fresh;
                        n_out_temp   = r_fresh;
                        n_out_upd    = 1'b1;
                    end else begin
                        n_out_temp   = r_held[r_ch];
                        n_out_upd    = 1'b0;
                    end
                    n_out_status = r_status;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
            r_cj        <= CJ_RESET;
            r_held[0]   <= CJ_RESET;
            r_held[1]   <= '0;
            r_held[2]   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_thr       <= n_thr;
            r_cj        <= n_cj;
            r_held      <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch         <= n_ch;
        r_code       <= n_code;
        r_v          <= n_v;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_tlo        <= n_tlo;
        r_rem        <= n_rem;
        r_den        <= n_den;
        r_quo        <= n_quo;
        r_cnt        <= n_cnt;
        r_fresh      <= n_fresh;
        r_status     <= n_status;
        r_out_temp   <= n_out_temp;
        r_out_status <= n_out_status;
        r_out_upd    <= n_out_upd;
    end

    assign o_out_valid    = r_out_valid;
    assign o_temperature  = r_out_temp;
    assign o_range_status = r_out_status;
    assign o_updated      = r_out_upd;

    a_search_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SEARCH |-> r_lo < r_hi)
        else $error("search bracket collapsed");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_den != '0) |-> r_rem < r_den)
        else $error("divider remainder not below segment width");

    a_tc_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_channel == CH_TC1 || i_channel == CH_TC2))
        |=> r_state == ST_CJ)
        else $error("thermocouple beat did not start the sequence");

    a_no_dropped_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_ch != CH_NONE)
        else $error("channel three beat entered the sequence");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HYST && r_out_valid && !i_out_ready) |=> r_state == ST_HYST)
        else $error("result finished while the output register was full");

endmodule
